// ----- rtl/core/pfrs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the page framebuffer refresh streamer.
// Holds geometry constants, action and command codes, payload and request types.
package pfrs_pkg;

	localparam int WIDTH  = 128;
	localparam int PAGES  = 8;
	localparam int DEPTH  = WIDTH * PAGES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [7:0] PHASE_FIRST_DATA = 8'd3;
	localparam logic [7:0] PHASE_LAST       = 8'(WIDTH + 2);
	localparam logic [2:0] PAGE_LAST        = 3'(PAGES - 1);

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	localparam logic [1:0] ACT_DRAW    = 2'd0;
	localparam logic [1:0] ACT_CLEAR   = 2'd1;
	localparam logic [1:0] ACT_REFRESH = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] col_x;
		logic [7:0] row_y;
		logic       pixel_on;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic              draw;
		logic              pixel_on;
		logic [2:0]        bit_sel;
		logic              clear;
	} fb_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

endpackage

// ----- rtl/core/pfrs_fb.sv -----
`timescale 1ns / 1ps
// Framebuffer store: one synchronous memory with read-modify-write for pixel draws.
// Also runs the clearing sweep after reset and on request. Uses pfrs_pkg.
module pfrs_fb
	import pfrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fb_req_t    req,
	output logic [7:0] rd_data,
	output logic       busy
);

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_q;
	logic              draw_s1;
	logic              on_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [7:0]        wr_data;

	always_comb begin
		if (on_s1) begin
			wr_data = rd_data_q | mask_s1;
		end else begin
			wr_data = rd_data_q & ~mask_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= 8'h00;
		end else if (draw_s1) begin
			mem[addr_s1] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
			addr_s1   <= req.addr;
			on_s1     <= req.pixel_on;
			mask_s1   <= 8'h80 >> req.bit_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_s1    <= 1'b0;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			draw_s1 <= req.rd_en && req.draw;
			if (req.clear) begin
				clearing_q <= 1'b1;
				clr_cnt_q  <= '0;
			end else if (clearing_q) begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clearing_q;

`ifndef SYNTH
	a_no_draw_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !draw_s1)
		else $error("pixel write-back overlaps the clearing sweep");

	a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.rd_en)
		else $error("store read issued during the clearing sweep");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clearing_q && !req.clear && clr_cnt_q == ADDR_W'(DEPTH - 1)) |=> !clearing_q)
		else $error("clearing sweep did not end at the last entry");
`endif

endmodule

// ----- rtl/core/page_framebuffer_refresh_streamer_unit.sv -----
`timescale 1ns / 1ps
// A refresh transfer's byte (header or store read) is registered at acceptance, then
// loaded into the output register once no stalled byte holds it. A new transfer is
// taken only after the last leaves the response state. Draw and clear give no output; a
// clear rewinds the refresh position at once. After reset and each clear the store is
// zeroed in a sweep of WIDTH*PAGES (1024) entries, taking no input meanwhile. Uses pfrs_pkg, pfrs_fb.
module page_framebuffer_refresh_streamer_unit
	import pfrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	state_t     state_q;
	state_t     state_d;
	logic       accept;
	logic       out_load;
	logic       fb_busy;
	logic [7:0] fb_rd_data;
	fb_req_t    fb_req;

	logic [2:0] refresh_page_q;
	logic [7:0] refresh_phase_q;

	logic [1:0] act_s1;
	logic [7:0] hdr_byte_s1;
	logic       is_data_s1;
	logic       last_s1;

	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       draw_ok;
	logic [2:0] draw_page;
	logic [7:0] hdr_byte;
	logic       cur_is_data;
	logic       cur_last;

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (act_s1 != ACT_REFRESH || !out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = fb_busy;
			ST_RESP: out_load = (act_s1 == ACT_REFRESH) && (!out_valid_q || !out_stall);
			default: in_stall = 1'b1;
		endcase
	end

	assign draw_ok   = (9'(in_data.col_x) < 9'(WIDTH)) && (9'(in_data.row_y) < 9'(8 * PAGES));
	assign draw_page = PAGE_LAST - in_data.row_y[5:3];

	always_comb begin
		unique case (refresh_phase_q)
			8'd0:    hdr_byte = CMD_PAGE_BASE + {5'b0, refresh_page_q};
			8'd1:    hdr_byte = CMD_COL_LOW;
			8'd2:    hdr_byte = CMD_COL_HIGH;
			default: hdr_byte = 8'h00;
		endcase
	end

	assign cur_is_data = refresh_phase_q >= PHASE_FIRST_DATA;
	assign cur_last    = (refresh_page_q == PAGE_LAST) && (refresh_phase_q == PHASE_LAST);

	always_comb begin
		fb_req          = '0;
		fb_req.pixel_on = in_data.pixel_on;
		fb_req.bit_sel  = in_data.row_y[2:0];
		fb_req.clear    = accept && (in_data.action == ACT_CLEAR);
		if (in_data.action == ACT_DRAW) begin
			fb_req.addr  = ADDR_W'(draw_page) * ADDR_W'(WIDTH) + ADDR_W'(in_data.col_x);
			fb_req.rd_en = accept && draw_ok;
			fb_req.draw  = 1'b1;
		end else begin
			fb_req.addr  = ADDR_W'(refresh_page_q) * ADDR_W'(WIDTH)
				+ ADDR_W'(refresh_phase_q - PHASE_FIRST_DATA);
			fb_req.rd_en = accept && (in_data.action == ACT_REFRESH) && cur_is_data;
		end
	end

	pfrs_fb u_fb (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fb_req),
		.rd_data (fb_rd_data),
		.busy    (fb_busy)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_byte_s1 <= hdr_byte;
			is_data_s1  <= cur_is_data;
			last_s1     <= cur_last;
		end
		if (out_load) begin
			out_data_q.out_byte   <= is_data_s1 ? fb_rd_data : hdr_byte_s1;
			out_data_q.is_data    <= is_data_s1;
			out_data_q.frame_last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			act_s1          <= ACT_DRAW;
			refresh_page_q  <= '0;
			refresh_phase_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				act_s1 <= in_data.action;
				if (in_data.action == ACT_CLEAR) begin
					refresh_page_q  <= '0;
					refresh_phase_q <= '0;
				end else if (in_data.action == ACT_REFRESH) begin
					if (refresh_phase_q == PHASE_LAST) begin
						refresh_phase_q <= '0;
						if (refresh_page_q == PAGE_LAST) begin
							refresh_page_q <= '0;
						end else begin
							refresh_page_q <= refresh_page_q + 3'd1;
						end
					end else begin
						refresh_phase_q <= refresh_phase_q + 8'd1;
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.action == ACT_CLEAR) |=> fb_busy)
		else $error("clear transfer did not start the clearing sweep");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(refresh_phase_q <= PHASE_LAST) && (refresh_page_q <= PAGE_LAST))
		else $error("refresh position out of range");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.frame_last) |-> out_data_q.is_data)
		else $error("frame end flagged on a command byte");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("output register overwritten while stalled");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for page_framebuffer_refresh_streamer_unit.
// Mirrors the pixel store and the refresh scan position to predict every streamed byte.
// Depends on pfrs_pkg for the payload types, geometry and command codes.
module tb;
	import pfrs_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int         FRAME_BYTES = PAGES * (WIDTH + 3);
	localparam int         QUIET_LIMIT = 5000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	logic [7:0] fb_mirror [DEPTH];
	logic [2:0] scan_page;
	logic [7:0] scan_phase;
	out_item_t  refresh_expect [$];

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_frame_ends = 0;
	int n_clears = 0;
	int n_draws = 0;
	int quiet_cycles = 0;

	page_framebuffer_refresh_streamer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic void apply_action(input in_item_t it);
		out_item_t res;
		int pg;
		int bitn;
		case (it.action)
			ACT_DRAW: begin
				n_draws++;
				if (it.col_x < WIDTH && it.row_y < 8 * PAGES) begin
					pg = PAGES - 1 - int'(it.row_y) / 8;
					bitn = 7 - int'(it.row_y) % 8;
					fb_mirror[pg * WIDTH + int'(it.col_x)][bitn] = it.pixel_on;
				end
			end
			ACT_CLEAR: begin
				n_clears++;
				foreach (fb_mirror[i])
					fb_mirror[i] = 8'h00;
				scan_page = 3'd0;
				scan_phase = 8'd0;
			end
			ACT_REFRESH: begin
				res = '0;
				if (scan_phase == 8'd0) begin
					res.out_byte = CMD_PAGE_BASE + {5'd0, scan_page};
				end else if (scan_phase == 8'd1) begin
					res.out_byte = CMD_COL_LOW;
				end else if (scan_phase == 8'd2) begin
					res.out_byte = CMD_COL_HIGH;
				end else begin
					res.out_byte = fb_mirror[int'(scan_page) * WIDTH
						+ int'(scan_phase - PHASE_FIRST_DATA)];
					res.is_data = 1'b1;
					res.frame_last = (scan_page == PAGE_LAST && scan_phase == PHASE_LAST);
				end
				refresh_expect.push_back(res);
				if (scan_phase == PHASE_LAST) begin
					scan_phase = 8'd0;
					scan_page = (scan_page == PAGE_LAST) ? 3'd0 : scan_page + 3'd1;
				end else begin
					scan_phase = scan_phase + 8'd1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic in_item_t make_item(input logic [1:0] act);
		in_item_t it;
		it.action = act;
		if (act == ACT_DRAW && $urandom_range(0, 3) != 0) begin
			it.col_x = 8'($urandom_range(0, WIDTH - 1));
			it.row_y = 8'($urandom_range(0, 8 * PAGES - 1));
		end else begin
			it.col_x = 8'($urandom);
			it.row_y = 8'($urandom);
		end
		it.pixel_on = ($urandom_range(0, 3) != 0);
		return it;
	endfunction

	task automatic push_action(input in_item_t it);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_action(it);
		n_sent++;
	endtask

	task automatic wait_stream_drained();
		in_valid <= 1'b0;
		while (refresh_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic draw(input int x, input int y, input bit on);
		push_action(in_item_t'{ACT_DRAW, 8'(x), 8'(y), on});
	endtask

	task automatic test_draw_extremes();
		draw(0, 0, 1'b1);
		draw(WIDTH - 1, 8 * PAGES - 1, 1'b1);
		draw(WIDTH - 1, 0, 1'b1);
		draw(0, 8 * PAGES - 1, 1'b1);
		draw(5, 9, 1'b1);
		draw(5, 9, 1'b0);
		draw(WIDTH, 0, 1'b1);
		draw(0, 8 * PAGES, 1'b1);
		draw(255, 255, 1'b1);
		draw(255, 255, 1'b0);
		push_action(make_item(ACT_UNUSED));
	endtask

	task automatic test_refresh_header();
		repeat (5) push_action(make_item(ACT_REFRESH));
	endtask

	task automatic test_clear_mid_refresh();
		push_action(make_item(ACT_CLEAR));
		repeat (3) push_action(make_item(ACT_REFRESH));
		draw(0, 8 * PAGES - 1, 1'b1);
		push_action(make_item(ACT_REFRESH));
		wait_stream_drained();
	endtask

	// Runs the scan past the end of the frame so the last-byte flag and the wrap are seen.
	task automatic test_frame_wrap();
		int refreshes;
		logic [1:0] act;
		refreshes = 0;
		while (refreshes < FRAME_BYTES + 12) begin
			if (n_sent % 64 == 0)
				tx_gaps = ($urandom_range(0, 3) != 0);
			act = ($urandom_range(0, 9) == 0) ? ACT_DRAW : ACT_REFRESH;
			push_action(make_item(act));
			if (act == ACT_REFRESH) begin
				refreshes++;
				if (refreshes == 500)
					wait_stream_drained();
			end
		end
		wait_stream_drained();
	endtask

	task automatic test_random_mix();
		int r;
		logic [1:0] act;
		for (int i = 0; i < 250; i++) begin
			if (i % 32 == 0)
				tx_gaps = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 45)
				act = ACT_REFRESH;
			else if (r < 80)
				act = ACT_DRAW;
			else if (r < 86)
				act = ACT_CLEAR;
			else
				act = ACT_UNUSED;
			push_action(make_item(act));
		end
	endtask

	initial begin : result_checker
		int hold;
		out_item_t want;
		hold = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				n_checked++;
				if (out_data.frame_last === 1'b1)
					n_frame_ends++;
				if (refresh_expect.size() == 0) begin
					report($sformatf("unexpected byte %02h", out_data.out_byte));
				end else begin
					want = refresh_expect.pop_front();
					if (out_data.out_byte !== want.out_byte)
						report($sformatf("byte %0d: out_byte %02h, want %02h",
							n_checked, out_data.out_byte, want.out_byte));
					if (out_data.is_data !== want.is_data)
						report($sformatf("byte %0d: is_data %b, want %b",
							n_checked, out_data.is_data, want.is_data));
					if (out_data.frame_last !== want.frame_last)
						report($sformatf("byte %0d: frame_last %b, want %b",
							n_checked, out_data.frame_last, want.frame_last));
				end
				if (n_checked % 64 == 0)
					rx_gaps = ($urandom_range(0, 3) != 0);
				hold = rx_gaps ? $urandom_range(0, 15) : 0;
				out_stall <= (hold != 0);
			end else if (out_stall == 1'b1 && out_valid === 1'b1) begin
				hold--;
				if (hold <= 0)
					out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("** page_framebuffer_refresh_streamer_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		foreach (fb_mirror[i])
			fb_mirror[i] = 8'h00;
		scan_page = 3'd0;
		scan_phase = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_draw_extremes();
		test_refresh_header();
		test_clear_mid_refresh();
		test_frame_wrap();
		test_random_mix();

		wait_stream_drained();
		repeat (16) @(posedge clk);
		$display("Run: %0d transfers in (%0d draws, %0d clears), %0d bytes checked,",
			n_sent, n_draws, n_clears, n_checked);
		$display("%0d frame ends seen, %0d mismatches.", n_frame_ends, mismatches);
		if (mismatches == 0 && refresh_expect.size() == 0) begin
			$display("** page_framebuffer_refresh_streamer_unit: PASSED **");
		end else begin
			$display("** page_framebuffer_refresh_streamer_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ----- page_framebuffer_refresh_streamer_unit.f -----
rtl/core/pfrs_pkg.sv
rtl/core/pfrs_fb.sv
rtl/core/page_framebuffer_refresh_streamer_unit.sv
tb/tb.sv
